FILE: hdl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// PID controller step: shared package
// Widths, register indexes and sequencer states of the fixed-point PID step.
// ----------------------------------------------------------------------------
package pcs_pkg;

    // Value, gain and register format: signed Q16.16.
    localparam int VALUE_W   = 32;
    // Integral accumulator: signed, 16 fraction bits.
    localparam int ACCUM_W   = 48;
    // Elapsed time: unsigned Q8.16 seconds.
    localparam int DT_W      = 24;
    localparam int FRAC_W    = 16;

    // Shared multiplier: 33 x 33 signed, so unsigned 32-bit operands also fit.
    localparam int MUL_W     = VALUE_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    // Full gain times integral product.
    localparam int IPROD_W   = VALUE_W + ACCUM_W;
    // Half of the integral, taken by the multiplier in two passes.
    localparam int IHALF_W   = ACCUM_W / 2;
    // Saturation width of the I term.
    localparam int TERM_W    = 62;
    // Command sum before clamping.
    localparam int SUM_W     = 64;

    // Derivative divider: two quotient bits per cycle over the product magnitude.
    localparam int DIV_STEPS = PROD_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PROPORTIONAL_GAIN = 3'd0,
        CFG_INTEGRAL_GAIN     = 3'd1,
        CFG_DERIVATIVE_GAIN   = 3'd2,
        CFG_SENSOR_SCALE      = 3'd3,
        CFG_OUTPUT_MAXIMUM    = 3'd4,
        CFG_OUTPUT_MINIMUM    = 3'd5
    } cfg_index_t;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_SCALE = 13'b0000000000010,
        ST_ERR   = 13'b0000000000100,
        ST_INC   = 13'b0000000001000,
        ST_INTEG = 13'b0000000010000,
        ST_PTERM = 13'b0000000100000,
        ST_ILO   = 13'b0000001000000,
        ST_IHI   = 13'b0000010000000,
        ST_ITERM = 13'b0000100000000,
        ST_DNUM  = 13'b0001000000000,
        ST_DIV   = 13'b0010000000000,
        ST_DSAT  = 13'b0100000000000,
        ST_SUM   = 13'b1000000000000
    } state_t;

endpackage

FILE: hdl/pid_controller_step_unit.sv
// ----------------------------------------------------------------------------
// PID controller step unit
// Positional fixed-point PID step: one command per sensor request.
// ----------------------------------------------------------------------------
// Usage:
// Gains, sensor scale and output limits are written through the plain write
// port (cfg_write, cfg_index, cfg_data) while the unit is idle. Each request
// on the input channel (in_valid/in_ready) carries a setpoint, one sensor
// sample and the elapsed time since the previous sample. One result request
// (command, error and clamp flag) leaves on the output channel
// (out_valid/out_ready) for every input request, in order.
// A request with a nonzero delta_time passes through sequenced multiplies and
// adds on the single shared 33x33 multiplier, the radix-4 restoring divider
// that forms the derivative term, and saturation, sum and handoff. With
// delta_time equal to zero the divider is skipped. in_ready is high only
// while the sequencer idles, so a new request is accepted only after the
// previous result has been handed to the output register.
// The result sits in an output register; a stalled receiver only holds the
// sequencer in its final state once a second result is ready to go out.
// Reset loads the register reset values and clears the integral, the
// previous error and the held derivative term.
// ----------------------------------------------------------------------------
module pid_controller_step_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [pcs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pcs_pkg::VALUE_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [pcs_pkg::VALUE_W-1:0]  target_value,
    input  logic signed [pcs_pkg::VALUE_W-1:0]  sensor_value,
    input  logic [pcs_pkg::DT_W-1:0]            delta_time,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pcs_pkg::VALUE_W-1:0]  drive_command,
    output logic signed [pcs_pkg::VALUE_W-1:0]  error_value,
    output logic                                output_clamped
);
    import pcs_pkg::*;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [ACCUM_W-1:0] ACCUM_MAX = {1'b0, {(ACCUM_W-1){1'b1}}};
    localparam logic signed [ACCUM_W-1:0] ACCUM_MIN = {1'b1, {(ACCUM_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]   TERM_MAX  =
        {{(SUM_W-TERM_W+1){1'b0}}, {(TERM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]   TERM_MIN  =
        {{(SUM_W-TERM_W+1){1'b1}}, {(TERM_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] SCALE_RESET = VALUE_W'(1) << FRAC_W;

    // Configuration registers.
    logic signed [VALUE_W-1:0] kp_reg, ki_reg, kd_reg, scale_reg, max_reg, min_reg;

    // Sequencer and persistent controller state.
    state_t                    state_reg, state_next;
    logic signed [VALUE_W-1:0] prev_err_reg, prev_err_next;
    logic signed [ACCUM_W-1:0] integ_reg, integ_next;
    logic signed [VALUE_W-1:0] deriv_reg, deriv_next;
    logic                      out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;

    // Working registers of the current request.
    logic signed [VALUE_W-1:0] sp_reg, sv_reg;
    logic [DT_W-1:0]           dt_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [VALUE_W-1:0] err_reg, err_next;
    logic signed [IPROD_W-1:0] iprod_reg, iprod_next;
    logic signed [SUM_W-1:0]   acc_reg, acc_next;
    logic [PROD_W-1:0]         quo_reg, quo_next;
    logic [DT_W-1:0]           rem_reg, rem_next;
    logic                      dneg_reg, dneg_next;
    logic signed [VALUE_W-1:0] cmd_reg, cmd_next;
    logic signed [VALUE_W-1:0] errout_reg, errout_next;
    logic                      clamp_reg, clamp_next;

    // Shared multiplier.
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    // Datapath helpers.
    logic signed [ACCUM_W-1:0] shifted;
    logic signed [ACCUM_W:0]   err_diff;
    logic signed [VALUE_W-1:0] err_sat;
    logic signed [ACCUM_W:0]   integ_sum;
    logic signed [ACCUM_W-1:0] integ_sat;
    logic signed [SUM_W-1:0]   iterm;
    logic signed [SUM_W-1:0]   iterm_sat;
    logic signed [MUL_W-1:0]   err_delta;
    logic [PROD_W-1:0]         num_mag;
    logic [DT_W:0]             div_t1, div_t2;
    logic                      div_ge1, div_ge2;
    logic [DT_W-1:0]           div_r1, div_r2;
    logic                      quo_big;
    logic signed [VALUE_W-1:0] deriv_sat;
    logic signed [SUM_W-1:0]   sum_value;
    logic signed [SUM_W-1:0]   max_ext, min_ext;

    assign mul_p = mul_a * mul_b;

    // A Q.32 product floored back to Q.16; every such product here fits
    // in ACCUM_W bits after the shift.
    assign shifted = prod_reg[ACCUM_W+FRAC_W-1:FRAC_W];

    // Error: setpoint minus scaled sensor, saturated to the value width.
    assign err_diff = {{(ACCUM_W+1-VALUE_W){sp_reg[VALUE_W-1]}}, sp_reg}
                    - {shifted[ACCUM_W-1], shifted};
    always_comb
    begin
        if (err_diff[ACCUM_W:VALUE_W-1] == {(ACCUM_W-VALUE_W+2){1'b0}} ||
            err_diff[ACCUM_W:VALUE_W-1] == {(ACCUM_W-VALUE_W+2){1'b1}})
        begin
            err_sat = err_diff[VALUE_W-1:0];
        end
        else if (err_diff[ACCUM_W])
        begin
            err_sat = VALUE_MIN;
        end
        else
        begin
            err_sat = VALUE_MAX;
        end
    end

    // Integral update with saturation.
    assign integ_sum = {integ_reg[ACCUM_W-1], integ_reg} + {shifted[ACCUM_W-1], shifted};
    always_comb
    begin
        if (integ_sum[ACCUM_W] == integ_sum[ACCUM_W-1])
        begin
            integ_sat = integ_sum[ACCUM_W-1:0];
        end
        else if (integ_sum[ACCUM_W])
        begin
            integ_sat = ACCUM_MIN;
        end
        else
        begin
            integ_sat = ACCUM_MAX;
        end
    end

    // I term: full product floored to Q.16 and saturated to the term width.
    assign iterm = iprod_reg[SUM_W+FRAC_W-1:FRAC_W];
    always_comb
    begin
        if (iterm[SUM_W-1:TERM_W-1] == {(SUM_W-TERM_W+1){1'b0}} ||
            iterm[SUM_W-1:TERM_W-1] == {(SUM_W-TERM_W+1){1'b1}})
        begin
            iterm_sat = iterm;
        end
        else if (iterm[SUM_W-1])
        begin
            iterm_sat = TERM_MIN;
        end
        else
        begin
            iterm_sat = TERM_MAX;
        end
    end

    assign err_delta = {err_reg[VALUE_W-1], err_reg} - {prev_err_reg[VALUE_W-1], prev_err_reg};
    assign num_mag   = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : prod_reg;

    // Two restoring division steps per cycle.
    assign div_t1  = {rem_reg, quo_reg[PROD_W-1]};
    assign div_ge1 = div_t1 >= {1'b0, dt_reg};
    assign div_r1  = div_ge1 ? DT_W'(div_t1 - {1'b0, dt_reg}) : div_t1[DT_W-1:0];
    assign div_t2  = {div_r1, quo_reg[PROD_W-2]};
    assign div_ge2 = div_t2 >= {1'b0, dt_reg};
    assign div_r2  = div_ge2 ? DT_W'(div_t2 - {1'b0, dt_reg}) : div_t2[DT_W-1:0];

    // Derivative quotient saturation; the magnitude allows one extra step
    // on the negative side.
    assign quo_big = |quo_reg[PROD_W-1:VALUE_W];
    always_comb
    begin
        if (dneg_reg)
        begin
            if (quo_big || (quo_reg[VALUE_W-1] && |quo_reg[VALUE_W-2:0]))
            begin
                deriv_sat = VALUE_MIN;
            end
            else
            begin
                deriv_sat = VALUE_W'(-quo_reg[VALUE_W-1:0]);
            end
        end
        else
        begin
            if (quo_big || quo_reg[VALUE_W-1])
            begin
                deriv_sat = VALUE_MAX;
            end
            else
            begin
                deriv_sat = quo_reg[VALUE_W-1:0];
            end
        end
    end

    assign sum_value = acc_reg + {{(SUM_W-VALUE_W){deriv_reg[VALUE_W-1]}}, deriv_reg};
    assign max_ext   = {{(SUM_W-VALUE_W){max_reg[VALUE_W-1]}}, max_reg};
    assign min_ext   = {{(SUM_W-VALUE_W){min_reg[VALUE_W-1]}}, min_reg};

    // Sequencer: each multiply is issued in one state and its registered
    // product is consumed in the next.
    always_comb
    begin
        state_next     = state_reg;
        mul_a          = '0;
        mul_b          = '0;
        err_next       = err_reg;
        integ_next     = integ_reg;
        iprod_next     = iprod_reg;
        acc_next       = acc_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        dneg_next      = dneg_reg;
        cnt_next       = cnt_reg;
        deriv_next     = deriv_reg;
        prev_err_next  = prev_err_reg;
        cmd_next       = cmd_reg;
        errout_next    = errout_reg;
        clamp_next     = clamp_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                mul_a      = {scale_reg[VALUE_W-1], scale_reg};
                mul_b      = {sv_reg[VALUE_W-1], sv_reg};
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                err_next   = err_sat;
                state_next = ST_INC;
            end
            ST_INC:
            begin
                mul_a      = {err_reg[VALUE_W-1], err_reg};
                mul_b      = {{(MUL_W-DT_W){1'b0}}, dt_reg};
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                integ_next = integ_sat;
                mul_a      = {kp_reg[VALUE_W-1], kp_reg};
                mul_b      = {err_reg[VALUE_W-1], err_reg};
                state_next = ST_PTERM;
            end
            ST_PTERM:
            begin
                acc_next   = {{(SUM_W-ACCUM_W){shifted[ACCUM_W-1]}}, shifted};
                mul_a      = {ki_reg[VALUE_W-1], ki_reg};
                mul_b      = {{(MUL_W-IHALF_W){1'b0}}, integ_reg[IHALF_W-1:0]};
                state_next = ST_ILO;
            end
            ST_ILO:
            begin
                iprod_next = {{(IPROD_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                mul_a      = {ki_reg[VALUE_W-1], ki_reg};
                mul_b      = {{(MUL_W-IHALF_W){integ_reg[ACCUM_W-1]}},
                              integ_reg[ACCUM_W-1:IHALF_W]};
                state_next = ST_IHI;
            end
            ST_IHI:
            begin
                iprod_next = iprod_reg + {prod_reg[IPROD_W-IHALF_W-1:0], {IHALF_W{1'b0}}};
                state_next = ST_ITERM;
            end
            ST_ITERM:
            begin
                acc_next   = acc_reg + iterm_sat;
                mul_a      = {kd_reg[VALUE_W-1], kd_reg};
                mul_b      = err_delta;
                state_next = ST_DNUM;
            end
            ST_DNUM:
            begin
                quo_next  = num_mag;
                rem_next  = '0;
                dneg_next = prod_reg[PROD_W-1];
                cnt_next  = '0;
                if (dt_reg == '0)
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quo_next = {quo_reg[PROD_W-3:0], div_ge1, div_ge2};
                rem_next = div_r2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DSAT;
                end
            end
            ST_DSAT:
            begin
                deriv_next = deriv_sat;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (sum_value > max_ext)
                    begin
                        cmd_next   = max_reg;
                        clamp_next = 1'b1;
                    end
                    else if (sum_value < min_ext)
                    begin
                        cmd_next   = min_reg;
                        clamp_next = 1'b1;
                    end
                    else
                    begin
                        cmd_next   = sum_value[VALUE_W-1:0];
                        clamp_next = 1'b0;
                    end
                    errout_next    = err_reg;
                    prev_err_next  = err_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, configuration and controller memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            prev_err_reg  <= '0;
            integ_reg     <= '0;
            deriv_reg     <= '0;
            cnt_reg       <= '0;
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            scale_reg     <= SCALE_RESET;
            max_reg       <= VALUE_MAX;
            min_reg       <= VALUE_MIN;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            prev_err_reg  <= prev_err_next;
            integ_reg     <= integ_next;
            deriv_reg     <= deriv_next;
            cnt_reg       <= cnt_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PROPORTIONAL_GAIN: kp_reg    <= cfg_data;
                    CFG_INTEGRAL_GAIN:     ki_reg    <= cfg_data;
                    CFG_DERIVATIVE_GAIN:   kd_reg    <= cfg_data;
                    CFG_SENSOR_SCALE:      scale_reg <= cfg_data;
                    CFG_OUTPUT_MAXIMUM:    max_reg   <= cfg_data;
                    CFG_OUTPUT_MINIMUM:    min_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers; these need no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sp_reg <= target_value;
            sv_reg <= sensor_value;
            dt_reg <= delta_time;
        end
        prod_reg   <= mul_p;
        err_reg    <= err_next;
        iprod_reg  <= iprod_next;
        acc_reg    <= acc_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        dneg_reg   <= dneg_next;
        cmd_reg    <= cmd_next;
        errout_reg <= errout_next;
        clamp_reg  <= clamp_next;
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign drive_command  = cmd_reg;
    assign error_value    = errout_reg;
    assign output_clamped = clamp_reg;

endmodule
